[hw/rtl/obec_pkg.sv]
// Types and constants for the online bipartite edge checker.
`timescale 1ns / 1ps
package obec_pkg;

  localparam int unsigned NodeW  = 10;
  localparam int unsigned CountW = 11;
  localparam int unsigned EdgeW  = 16;
  localparam int unsigned StatW  = 3;

  typedef enum logic [StatW-1:0] {
    ST_MERGED  = 3'd0,
    ST_CONSIST = 3'd1,
    ST_ODD     = 3'd2,
    ST_IGNORED = 3'd3,
    ST_CLEARED = 3'd4,
    ST_BADNODE = 3'd5
  } status_e;

  typedef enum logic {
    OP_CLEAR = 1'b0,
    OP_EDGE  = 1'b1
  } opcode_e;

  typedef struct packed {
    logic             opcode;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
    logic             last_edge;
  } in_beat_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [EdgeW-1:0] edge_number;
    logic [EdgeW-1:0] first_odd_edge;
    logic             end_no_odd_cycle;
  } out_beat_t;

  typedef enum logic [4:0] {
    S_CLR,       // clearing sweep
    S_IDLE,
    S_FA_RD,     // find root of a: read parent
    S_FA_CHK,
    S_FB_RD,
    S_FB_CHK,
    S_PA_RD,     // path compression of a
    S_PA_CHK,
    S_PB_RD,
    S_PB_CHK,
    S_COL_RD,    // read colors of a and b
    S_COL_CHK,
    S_SZ_RD,     // read sizes of both roots
    S_SZ_A,
    S_SZ_B,
    S_VCLR,      // clear visited marks
    S_W_POP,     // pop node from walk queue
    S_W_HEAD,
    S_W_ADJ,     // read adjacency entry
    S_W_TGT,
    S_W_VIS,
    S_JOIN,
    S_LINK_A,
    S_LINK_A2,
    S_LINK_B,
    S_LINK_B2,
    S_OUT
  } state_e;

endpackage

[hw/rtl/online_bipartite_edge_checker_top.sv]
// Top level of the online bipartite edge checker: union-find over memories.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i/in_ready_o   | in_data_i  (obec_pkg::in_beat_t)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (obec_pkg::out_beat_t)
//   cfg     | input     | cfg_we_i                | cfg_data_i (node_count)
//
// One item at a time. A bad, ignored or clear item goes from S_IDLE straight to
// S_OUT, which registers its result. An edge runs two find walks and two
// path-compression walks, a read and a check state per tree level, then color
// and size reads. A join also sweeps the visited marks, walks the smaller component
// node by node and entry by entry, then links the roots and adds two adjacency
// entries, all bound by the one read port and one write port of each memory.
// Reset and clear run a sweep over all NODES entries with no beat taken.
// A result waits in the output register; the next beat is taken meanwhile and
// stalls only when its own result is ready while the register is still full.
`timescale 1ns / 1ps
module online_bipartite_edge_checker_top #(
  parameter int unsigned NODES = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  obec_pkg::in_beat_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output obec_pkg::out_beat_t   out_data_o,
  input  logic                  cfg_we_i,
  input  logic [10:0]           cfg_data_i
);
  import obec_pkg::*;

  localparam int unsigned IW = (NODES > 1) ? $clog2(NODES) : 1;   // node index
  localparam int unsigned SW = IW + 1;                            // size
  localparam int unsigned AC = 2 * (NODES - 1);                   // adjacency cap
  localparam int unsigned AW = $clog2(AC + 1);                    // entry+1 code
  localparam int unsigned XW = (AC > 1) ? $clog2(AC) : 1;         // entry index

  // memories
  logic [IW-1:0] par_mem [NODES];
  logic [SW-1:0] sz_mem  [NODES];
  logic          col_mem [NODES];
  logic          vis_mem [NODES];
  logic [AW-1:0] head_mem[NODES];
  logic [AW-1:0] nxt_mem [AC];
  logic [IW-1:0] tgt_mem [AC];
  logic [IW-1:0] q_mem   [NODES];

  state_e state_q, state_d;
  logic [CountW-1:0] ncount_q;
  logic [SW-1:0]     sweep_q, sweep_d;
  logic [EdgeW-1:0]  ecnt_q, ecnt_d, first_q, first_d;
  logic              conf_q, conf_d;
  logic [AW:0]       used_q, used_d;
  logic [IW-1:0]     a_q, a_d, b_q, b_d, x_q, x_d, ra_q, ra_d, rb_q, rb_d;
  logic [IW-1:0]     v_q, v_d, t_q, t_d;
  logic              last_q, last_d, cola_q, cola_d, colv_q, colv_d;
  logic [SW-1:0]     sza_q, sza_d;
  logic              bigb_q, bigb_d;   // b side is recolored
  logic [AW-1:0]     e_q, e_d;
  logic [SW-1:0]     qh_q, qh_d, qt_q, qt_d;
  logic [StatW-1:0]  st_q, st_d;
  logic              ov_q, ov_d;
  out_beat_t         od_q, od_d;

  // memory port controls
  logic [IW-1:0] par_ra, par_wa, par_wd;  logic par_we;  logic [IW-1:0] par_rd;
  logic [IW-1:0] sz_ra, sz_wa;  logic [SW-1:0] sz_wd;  logic sz_we;  logic [SW-1:0] sz_rd;
  logic [IW-1:0] col_ra, col_wa;  logic col_wd, col_we, col_rd;
  logic [IW-1:0] vis_ra, vis_wa;  logic vis_wd, vis_we, vis_rd;
  logic [IW-1:0] hd_ra, hd_wa;  logic [AW-1:0] hd_wd, hd_rd;  logic hd_we;
  logic [XW-1:0] ad_ra, ad_wa;  logic [AW-1:0] nx_wd, nx_rd;  logic [IW-1:0] tg_wd, tg_rd;
  logic          ad_we;
  logic [IW-1:0] q_ra, q_wa, q_wd, q_rd;  logic q_we;

  always_ff @(posedge clk_i) begin
    if (par_we) par_mem[par_wa] <= par_wd;
    par_rd <= par_mem[par_ra];
    if (sz_we) sz_mem[sz_wa] <= sz_wd;
    sz_rd <= sz_mem[sz_ra];
    if (col_we) col_mem[col_wa] <= col_wd;
    col_rd <= col_mem[col_ra];
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_rd <= vis_mem[vis_ra];
    if (hd_we) head_mem[hd_wa] <= hd_wd;
    hd_rd <= head_mem[hd_ra];
    if (ad_we) begin
      nxt_mem[ad_wa] <= nx_wd;
      tgt_mem[ad_wa] <= tg_wd;
    end
    nx_rd <= nxt_mem[ad_ra];
    tg_rd <= tgt_mem[ad_ra];
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd <= q_mem[q_ra];
  end

  logic [31:0]     lim;
  logic            out_free, in_fire, bad;
  assign lim = (32'(ncount_q) < NODES) ? 32'(ncount_q) : 32'(NODES);
  assign out_free = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire = in_valid_i && in_ready_o;
  assign bad = (32'(in_data_i.node_a) >= lim) || (32'(in_data_i.node_b) >= lim);

  always_comb begin
    state_d = state_q;  sweep_d = sweep_q;  ecnt_d = ecnt_q;  first_d = first_q;
    conf_d = conf_q;  used_d = used_q;  a_d = a_q;  b_d = b_q;  x_d = x_q;
    ra_d = ra_q;  rb_d = rb_q;  v_d = v_q;  t_d = t_q;  last_d = last_q;
    cola_d = cola_q;  colv_d = colv_q;  sza_d = sza_q;  bigb_d = bigb_q;
    e_d = e_q;  qh_d = qh_q;  qt_d = qt_q;  st_d = st_q;
    ov_d = ov_q && !out_ready_i;  od_d = od_q;
    par_ra = x_q;  par_wa = x_q;  par_wd = x_q;  par_we = 1'b0;
    sz_ra = ra_q;  sz_wa = ra_q;  sz_wd = sza_q;  sz_we = 1'b0;
    col_ra = a_q;  col_wa = t_q;  col_wd = 1'b0;  col_we = 1'b0;
    vis_ra = t_q;  vis_wa = t_q;  vis_wd = 1'b1;  vis_we = 1'b0;
    hd_ra = v_q;  hd_wa = a_q;  hd_wd = '0;  hd_we = 1'b0;
    ad_ra = XW'(e_q - AW'(1));  ad_wa = XW'(used_q);  nx_wd = hd_rd;  tg_wd = b_q;
    ad_we = 1'b0;
    q_ra = qh_q[IW-1:0];  q_wa = qt_q[IW-1:0];  q_wd = t_q;  q_we = 1'b0;

    unique case (state_q)
      S_CLR: begin
        par_wa = sweep_q[IW-1:0];  par_wd = sweep_q[IW-1:0];  par_we = 1'b1;
        sz_wa = sweep_q[IW-1:0];  sz_wd = SW'(1);  sz_we = 1'b1;
        col_wa = sweep_q[IW-1:0];  col_wd = 1'b0;  col_we = 1'b1;
        vis_wa = sweep_q[IW-1:0];  vis_wd = 1'b0;  vis_we = 1'b1;
        hd_wa = sweep_q[IW-1:0];  hd_wd = '0;  hd_we = 1'b1;
        sweep_d = sweep_q + SW'(1);
        if (sweep_q == SW'(NODES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          a_d = IW'(in_data_i.node_a);  b_d = IW'(in_data_i.node_b);
          x_d = IW'(in_data_i.node_a);  last_d = in_data_i.last_edge;
          if (in_data_i.opcode == OP_CLEAR) begin
            ecnt_d = '0;  first_d = '0;  conf_d = 1'b0;  used_d = '0;
            st_d = ST_CLEARED;  sweep_d = '0;  state_d = S_OUT;
          end else begin
            if (ecnt_q != '1) ecnt_d = ecnt_q + EdgeW'(1);
            if (conf_q) begin
              st_d = ST_IGNORED;  state_d = S_OUT;
            end else if (bad) begin
              st_d = ST_BADNODE;  state_d = S_OUT;
            end else state_d = S_FA_RD;
          end
        end
      end
      S_FA_RD:  state_d = S_FA_CHK;
      S_FA_CHK: begin
        if (par_rd == x_q) begin
          ra_d = x_q;  x_d = b_q;  state_d = S_FB_RD;
        end else begin
          x_d = par_rd;  state_d = S_FA_RD;
        end
      end
      S_FB_RD:  state_d = S_FB_CHK;
      S_FB_CHK: begin
        if (par_rd == x_q) begin
          rb_d = x_q;  x_d = a_q;  state_d = S_PA_RD;
        end else begin
          x_d = par_rd;  state_d = S_FB_RD;
        end
      end
      S_PA_RD:  state_d = S_PA_CHK;
      S_PA_CHK: begin
        if (par_rd == ra_q) begin
          x_d = b_q;  state_d = S_PB_RD;
        end else begin
          par_wd = ra_q;  par_we = 1'b1;  x_d = par_rd;  state_d = S_PA_RD;
        end
      end
      S_PB_RD:  state_d = S_PB_CHK;
      S_PB_CHK: begin
        if (par_rd == rb_q) state_d = S_COL_RD;
        else begin
          par_wd = rb_q;  par_we = 1'b1;  x_d = par_rd;  state_d = S_PB_RD;
        end
      end
      S_COL_RD: begin
        col_ra = a_q;  vis_ra = b_q;  state_d = S_COL_CHK;
      end
      S_COL_CHK: begin
        // color of b comes through a second read
        col_ra = b_q;  cola_d = col_rd;
        if (ra_q == rb_q) state_d = S_SZ_A;   // reuse slot as color-b read wait
        else state_d = S_SZ_RD;
        sz_ra = ra_q;
      end
      S_SZ_RD: begin
        colv_d = col_rd;  sza_d = sz_rd;  sz_ra = rb_q;  state_d = S_SZ_B;
      end
      S_SZ_A: begin
        // same component: col_rd is color of b
        if (col_rd == cola_q) begin
          conf_d = 1'b1;  first_d = ecnt_q;  st_d = ST_ODD;
        end else st_d = ST_CONSIST;
        state_d = S_OUT;
      end
      S_SZ_B: begin
        bigb_d = (sza_q >= sz_rd);
        sza_d = sza_q + sz_rd;
        // walk start and its new color: opposite of the other end
        if (sza_q >= sz_rd) begin
          t_d = b_q;  colv_d = ~cola_q;
        end else begin
          t_d = a_q;  colv_d = ~colv_q;
        end
        sweep_d = '0;  state_d = S_VCLR;
      end
      S_VCLR: begin
        vis_wa = sweep_q[IW-1:0];  vis_wd = 1'b0;  vis_we = 1'b1;
        sweep_d = sweep_q + SW'(1);
        if (sweep_q == SW'(NODES - 1)) begin
          vis_wa = sweep_q[IW-1:0];
          state_d = S_W_VIS;  qh_d = '0;  qt_d = '0;
        end
      end
      S_W_VIS: begin
        // visit t with color colv
        vis_wa = t_q;  vis_we = 1'b1;
        col_wa = t_q;  col_wd = colv_q;  col_we = 1'b1;
        if (qt_q < SW'(NODES)) begin
          q_we = 1'b1;  qt_d = qt_q + SW'(1);
        end
        // the start node has an empty queue; a neighbor resumes its list
        if (qt_q == '0) state_d = S_W_POP;
        else if (e_q == '0 || e_q > AW'(AC)) state_d = S_W_POP;
        else begin
          ad_ra = XW'(e_q - AW'(1));  state_d = S_W_TGT;
        end
      end
      S_W_POP: begin
        if (qh_q == qt_q) state_d = S_JOIN;
        else begin
          q_ra = qh_q[IW-1:0];  qh_d = qh_q + SW'(1);  state_d = S_W_HEAD;
        end
      end
      S_W_HEAD: begin
        v_d = q_rd;  hd_ra = q_rd;  col_ra = q_rd;  state_d = S_W_ADJ;
        e_d = '0;
      end
      S_W_ADJ: begin
        // first entry comes from the head read, later ones from next
        if (e_q == '0) begin
          e_d = hd_rd;  cola_d = col_rd;
        end
        if (e_q == '0 && (hd_rd == '0 || hd_rd > AW'(AC))) state_d = S_W_POP;
        else if (e_q == '0) begin
          ad_ra = XW'(hd_rd - AW'(1));  state_d = S_W_TGT;
        end else begin
          ad_ra = XW'(e_q - AW'(1));  state_d = S_W_TGT;
        end
      end
      S_W_TGT: begin
        // check visited next cycle
        t_d = tg_rd;  e_d = nx_rd;  vis_ra = tg_rd;  state_d = S_LINK_A;
      end
      S_LINK_A: begin
        // visited check for t (read issued in S_W_TGT)
        colv_d = ~cola_q;
        if (!vis_rd) state_d = S_W_VIS;
        else if (e_q == '0 || e_q > AW'(AC)) state_d = S_W_POP;
        else begin
          ad_ra = XW'(e_q - AW'(1));  state_d = S_W_TGT;
        end
      end
      S_JOIN: begin
        if (bigb_q) begin
          sz_wa = ra_q;  par_wa = rb_q;  par_wd = ra_q;
        end else begin
          sz_wa = rb_q;  par_wa = ra_q;  par_wd = rb_q;
        end
        sz_wd = sza_q;  sz_we = 1'b1;  par_we = 1'b1;
        hd_ra = a_q;  state_d = S_LINK_A2;
      end
      S_LINK_A2: begin
        if (used_q < (AW+1)'(AC)) begin
          ad_wa = XW'(used_q);  nx_wd = hd_rd;  tg_wd = b_q;  ad_we = 1'b1;
          hd_wa = a_q;  hd_wd = AW'(used_q + (AW+1)'(1));  hd_we = 1'b1;
          used_d = used_q + (AW+1)'(1);
        end
        state_d = S_LINK_B;
      end
      S_LINK_B: begin
        hd_ra = b_q;  state_d = S_LINK_B2;
      end
      S_LINK_B2: begin
        if (used_q < (AW+1)'(AC)) begin
          ad_wa = XW'(used_q);  nx_wd = hd_rd;  tg_wd = a_q;  ad_we = 1'b1;
          hd_wa = b_q;  hd_wd = AW'(used_q + (AW+1)'(1));  hd_we = 1'b1;
          used_d = used_q + (AW+1)'(1);
        end
        st_d = ST_MERGED;  state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          ov_d = 1'b1;
          od_d.status = st_q;
          if (st_q == ST_CLEARED) begin
            od_d.edge_number = '0;  od_d.first_odd_edge = '0;
            od_d.end_no_odd_cycle = 1'b0;  state_d = S_CLR;
          end else begin
            od_d.edge_number = ecnt_q;
            od_d.first_odd_edge = conf_q ? first_q : '0;
            od_d.end_no_odd_cycle = last_q && !conf_q;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;  sweep_q <= '0;  ecnt_q <= '0;  first_q <= '0;
      conf_q <= 1'b0;  used_q <= '0;  ov_q <= 1'b0;  ncount_q <= CountW'(1024);
      qh_q <= '0;  qt_q <= '0;
    end else begin
      state_q <= state_d;  sweep_q <= sweep_d;  ecnt_q <= ecnt_d;  first_q <= first_d;
      conf_q <= conf_d;  used_q <= used_d;  ov_q <= ov_d;  qh_q <= qh_d;  qt_q <= qt_d;
      if (cfg_we_i) ncount_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;  b_q <= b_d;  x_q <= x_d;  ra_q <= ra_d;  rb_q <= rb_d;
    v_q <= v_d;  t_q <= t_d;  last_q <= last_d;  cola_q <= cola_d;  colv_q <= colv_d;
    sza_q <= sza_d;  bigb_q <= bigb_d;  e_q <= e_d;  st_q <= st_d;  od_q <= od_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

[hw/rtl/obec_checker.sv]
// Port-level checks for the online bipartite edge checker, bound to the top.
`timescale 1ns / 1ps
module obec_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input obec_pkg::out_beat_t out_data_o
);
  import obec_pkg::*;

  a_in_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ST_BADNODE)
    else $error("status code out of range");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_CLEARED |->
      out_data_o.edge_number == '0 && out_data_o.first_odd_edge == '0)
    else $error("clear beat carries counts");

  a_odd_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_ODD |->
      out_data_o.first_odd_edge == out_data_o.edge_number && !out_data_o.end_no_odd_cycle)
    else $error("odd cycle beat inconsistent");
endmodule

bind online_bipartite_edge_checker_top obec_checker u_obec_checker (.*);
